// ----- sv/shortest_keyword_cover_window_macros.svh -----
// Assertion helpers for the keyword cover window block.
// Each check is clocked on clk_i and held off while rst_ni is low.
`ifndef SHORTEST_KEYWORD_COVER_WINDOW_MACROS_SVH
`define SHORTEST_KEYWORD_COVER_WINDOW_MACROS_SVH

// Same-cycle implication.
`define SKCW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("skcw assertion failed");

// Next-cycle implication.
`define SKCW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("skcw assertion failed");

`endif

// ----- sv/skcw_pkg.sv -----
`timescale 1ns / 1ps

package skcw_pkg;

  localparam int MAX_KEYWORDS     = 16;
  localparam int POSITION_BITS    = 16;
  localparam int CHAR_OFFSET_BITS = 20;

  localparam int CELL_IDX_BITS = (MAX_KEYWORDS > 1) ? $clog2(MAX_KEYWORDS) : 1;
  localparam int COUNT_BITS    = $clog2(MAX_KEYWORDS + 1);

  // Field widths of the word and result transfers.
  localparam int KW_INDEX_W  = 4;
  localparam int WORD_LEN_W  = 8;
  localparam int KW_COUNT_W  = 5;
  localparam int WIN_POS_W   = 16;
  localparam int WIN_CHARS_W = 20;
  localparam int MATCHED_W   = 5;

  // Register port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0]    REG_KEYWORD_COUNT = '0;
  localparam logic [KW_COUNT_W-1:0] KW_COUNT_RESET    = KW_COUNT_W'(1);

  typedef logic [POSITION_BITS-1:0]    pos_t;
  typedef logic [CHAR_OFFSET_BITS-1:0] chr_t;

  localparam pos_t POS_MAX = '1;
  localparam chr_t CHR_MAX = '1;

  // One slot of the recency list.
  typedef struct packed {
    logic                  valid;
    logic [KW_INDEX_W-1:0] kw;
    pos_t                  pos;
    chr_t                  chr;
  } entry_t;

  // Update command broadcast to every cell.
  typedef struct packed {
    logic                  push;
    logic                  clear;
    logic [KW_INDEX_W-1:0] kw;
  } cell_ctl_t;

  typedef struct packed {
    logic                   all_found;
    logic [WIN_POS_W-1:0]   window_begin;
    logic [WIN_POS_W-1:0]   window_end;
    logic [WIN_CHARS_W-1:0] window_chars;
    logic [MATCHED_W-1:0]   matched_keywords;
    logic                   final_result;
  } out_item_t;

endpackage

// ----- sv/skcw_ifs.sv -----
`timescale 1ns / 1ps

interface skcw_word_if;
  logic                             valid;
  logic                             ready;
  logic                             is_keyword;
  logic [skcw_pkg::KW_INDEX_W-1:0]  keyword_index;
  logic [skcw_pkg::WORD_LEN_W-1:0]  word_length;
  logic                             text_end;

  modport source (output valid, is_keyword, keyword_index, word_length, text_end,
                  input ready);
  modport sink (input valid, is_keyword, keyword_index, word_length, text_end,
                output ready);
endinterface

interface skcw_result_if;
  logic                              valid;
  logic                              ready;
  logic                              all_found;
  logic [skcw_pkg::WIN_POS_W-1:0]    window_begin;
  logic [skcw_pkg::WIN_POS_W-1:0]    window_end;
  logic [skcw_pkg::WIN_CHARS_W-1:0]  window_chars;
  logic [skcw_pkg::MATCHED_W-1:0]    matched_keywords;
  logic                              final_result;

  modport source (output valid, all_found, window_begin, window_end, window_chars,
                  matched_keywords, final_result, input ready);
  modport sink (input valid, all_found, window_begin, window_end, window_chars,
                matched_keywords, final_result, output ready);
endinterface

// ----- sv/skcw_cell.sv -----
`timescale 1ns / 1ps

module skcw_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  skcw_pkg::cell_ctl_t ctl_i,
  input  skcw_pkg::entry_t    prev_i,
  input  logic                above_i,
  output skcw_pkg::entry_t    q_o,
  output skcw_pkg::entry_t    upd_o,
  output logic                below_o
);

  logic                            valid_q;
  logic [skcw_pkg::KW_INDEX_W-1:0] kw_q;
  skcw_pkg::pos_t                  pos_q;
  skcw_pkg::chr_t                  chr_q;
  logic                            match;
  logic                            shift;

  assign q_o     = '{valid: valid_q, kw: kw_q, pos: pos_q, chr: chr_q};
  assign match   = valid_q && (kw_q == ctl_i.kw);
  // On a push, take the neighbor's slot unless the keyword sits in a cell closer to the head.
  assign shift   = ctl_i.push && !above_i;
  assign upd_o   = shift ? prev_i : q_o;
  assign below_o = above_i | match;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctl_i.clear ? 1'b0 : upd_o.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift) begin
      kw_q  <= prev_i.kw;
      pos_q <= prev_i.pos;
      chr_q <= prev_i.chr;
    end
  end

endmodule

// ----- sv/skcw_chain.sv -----
`timescale 1ns / 1ps

module skcw_chain (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  skcw_pkg::cell_ctl_t                  ctl_i,
  input  skcw_pkg::entry_t                     head_i,
  input  logic [skcw_pkg::CELL_IDX_BITS-1:0]   tail_sel_i,
  output logic                                 hit_o,
  output skcw_pkg::entry_t                     tail_o
);

  skcw_pkg::entry_t                  prev_w [skcw_pkg::MAX_KEYWORDS];
  skcw_pkg::entry_t                  q_w    [skcw_pkg::MAX_KEYWORDS];
  skcw_pkg::entry_t                  upd_w  [skcw_pkg::MAX_KEYWORDS];
  logic [skcw_pkg::MAX_KEYWORDS:0]   above;

  assign above[0] = 1'b0;
  assign hit_o    = above[skcw_pkg::MAX_KEYWORDS];

  for (genvar i = 0; i < skcw_pkg::MAX_KEYWORDS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_w[i] = head_i;
    end else begin : g_link
      assign prev_w[i] = q_w[i-1];
    end

    skcw_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl_i),
      .prev_i  (prev_w[i]),
      .above_i (above[i]),
      .q_o     (q_w[i]),
      .upd_o   (upd_w[i]),
      .below_o (above[i+1])
    );
  end

  // The least recent keyword sits at the last occupied cell after the update.
  always_comb begin
    tail_o = '0;
    for (int k = 0; k < skcw_pkg::MAX_KEYWORDS; k++) begin
      if (skcw_pkg::CELL_IDX_BITS'(k) == tail_sel_i) begin
        tail_o = upd_w[k];
      end
    end
  end

endmodule

// ----- sv/shortest_keyword_cover_window.sv -----
`timescale 1ns / 1ps
`include "shortest_keyword_cover_window_macros.svh"

// Shortest keyword cover window: takes one tokenized word per cycle and answers each word
// with one result transfer holding the shortest window so far that covers every keyword,
// registered in the cycle after the word transfer. A new word is taken whenever the result
// register is empty or its result leaves in the same cycle, so the block sustains one word
// per cycle; that figure is set by the move-to-front update of the keyword cell chain, whose
// last occupied cell gives the oldest keyword, followed by one subtract and compare against
// the best window. keyword_count (byte address 0) resets to 1 and may be written only while
// no word is in flight. After a word with text_end all per-text state clears at once.
module shortest_keyword_cover_window (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  skcw_word_if.sink                        word_i,
  skcw_result_if.source                    result_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [skcw_pkg::PADDR_W-1:0]     paddr,
  input  logic [skcw_pkg::PDATA_W-1:0]     pwdata,
  output logic [skcw_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);

  localparam int MK = skcw_pkg::MAX_KEYWORDS;

  logic [skcw_pkg::KW_COUNT_W-1:0]  kc_q;
  skcw_pkg::pos_t                   word_cnt_q;
  skcw_pkg::chr_t                   char_cnt_q;
  logic [skcw_pkg::COUNT_BITS-1:0]  total_q, total_d;
  logic [MK-1:0]                    seen_mask_q, seen_mask_d;
  skcw_pkg::pos_t                   newest_q, newest_d;
  logic                             best_found_q, best_found_d;
  skcw_pkg::chr_t                   best_chars_q, best_chars_d;
  skcw_pkg::pos_t                   best_begin_q, best_begin_d;
  skcw_pkg::pos_t                   best_end_q, best_end_d;
  logic                             out_valid_q;
  skcw_pkg::out_item_t              out_q, out_d;

  logic                             acc;
  logic                             last;
  logic [skcw_pkg::COUNT_BITS-1:0]  need;
  logic [MK-1:0]                    need_mask;
  logic [MK-1:0]                    kw_onehot;
  logic                             push;
  logic                             hit;
  logic                             newly;
  logic                             full;
  logic                             all_k_seen;
  logic                             take;
  skcw_pkg::pos_t                   pos, pend, oldest_pos, end_sat;
  skcw_pkg::chr_t                   cstart, cend, oldest_chr, span;
  logic [skcw_pkg::CHAR_OFFSET_BITS:0] cend_raw;
  skcw_pkg::cell_ctl_t              ctl;
  skcw_pkg::entry_t                 head;
  skcw_pkg::entry_t                 tail;
  logic [skcw_pkg::CELL_IDX_BITS-1:0] tail_sel;

  // Register port
  assign pready = 1'b1;
  assign prdata = (paddr[skcw_pkg::PADDR_W-1:2] == skcw_pkg::REG_KEYWORD_COUNT)
                ? skcw_pkg::PDATA_W'(kc_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kc_q <= skcw_pkg::KW_COUNT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[skcw_pkg::PADDR_W-1:2] == skcw_pkg::REG_KEYWORD_COUNT) begin
      kc_q <= pwdata[skcw_pkg::KW_COUNT_W-1:0];
    end
  end

  // Handshake
  assign word_i.ready = rst_ni && (!out_valid_q || result_o.ready);
  assign acc          = word_i.valid && word_i.ready;
  assign last         = word_i.text_end;

  always_comb begin
    need = (32'(kc_q) > MK) ? skcw_pkg::COUNT_BITS'(MK) : skcw_pkg::COUNT_BITS'(kc_q);
    for (int k = 0; k < MK; k++) begin
      need_mask[k] = (k < 32'(need));
      kw_onehot[k] = (32'(word_i.keyword_index) == k);
    end
  end

  assign push   = acc && word_i.is_keyword && (32'(word_i.keyword_index) < 32'(need));
  assign pos    = word_cnt_q;
  assign cstart = char_cnt_q;
  assign pend   = (pos == skcw_pkg::POS_MAX) ? pos : pos + 1'b1;
  assign cend_raw = (skcw_pkg::CHAR_OFFSET_BITS + 1)'(cstart)
                  + (skcw_pkg::CHAR_OFFSET_BITS + 1)'(word_i.word_length);
  assign cend   = cend_raw[skcw_pkg::CHAR_OFFSET_BITS] ? skcw_pkg::CHR_MAX
                : cend_raw[skcw_pkg::CHAR_OFFSET_BITS-1:0];

  assign ctl  = '{push: push, clear: acc && last, kw: word_i.keyword_index};
  assign head = '{valid: 1'b1, kw: word_i.keyword_index, pos: pos, chr: cstart};

  assign newly       = push && !hit;
  assign total_d     = total_q + skcw_pkg::COUNT_BITS'(newly);
  assign seen_mask_d = newly ? (seen_mask_q | kw_onehot) : seen_mask_q;
  assign tail_sel    = skcw_pkg::CELL_IDX_BITS'(total_d - 1'b1);
  assign newest_d    = push ? pos : newest_q;
  assign end_sat     = (newest_d == skcw_pkg::POS_MAX) ? newest_d : newest_d + 1'b1;

  skcw_chain u_chain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .head_i     (head),
    .tail_sel_i (tail_sel),
    .hit_o      (hit),
    .tail_o     (tail)
  );

  // While a required keyword was never seen, the oldest position and offset are forced to zero.
  assign full       = push && (total_d == need);
  assign all_k_seen = ((seen_mask_d & need_mask) == need_mask);
  assign oldest_pos = all_k_seen ? tail.pos : '0;
  assign oldest_chr = all_k_seen ? tail.chr : '0;
  assign span       = cend - oldest_chr;
  assign take       = full && (!best_found_q || span < best_chars_q);

  always_comb begin
    best_found_d = best_found_q;
    best_chars_d = best_chars_q;
    best_begin_d = best_begin_q;
    best_end_d   = best_end_q;
    if (take) begin
      best_found_d = 1'b1;
      best_chars_d = span;
      best_begin_d = oldest_pos;
      best_end_d   = pend;
    end
  end

  always_comb begin
    out_d.all_found        = best_found_d;
    out_d.window_begin     = best_found_d ? skcw_pkg::WIN_POS_W'(best_begin_d) : '0;
    out_d.window_end       = best_found_d ? skcw_pkg::WIN_POS_W'(best_end_d) : '0;
    out_d.window_chars     = best_found_d ? skcw_pkg::WIN_CHARS_W'(best_chars_d) : '0;
    out_d.matched_keywords = skcw_pkg::MATCHED_W'(total_d);
    out_d.final_result     = last;
    // Partial cover on the last word: span from oldest to newest keyword seen.
    if (last && !best_found_d && total_d != '0) begin
      out_d.window_begin = skcw_pkg::WIN_POS_W'(tail.pos);
      out_d.window_end   = skcw_pkg::WIN_POS_W'(end_sat);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_cnt_q   <= '0;
      char_cnt_q   <= '0;
      total_q      <= '0;
      seen_mask_q  <= '0;
      newest_q     <= '0;
      best_found_q <= 1'b0;
      best_chars_q <= skcw_pkg::CHR_MAX;
      best_begin_q <= '0;
      best_end_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (acc) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (acc && last) begin
        word_cnt_q   <= '0;
        char_cnt_q   <= '0;
        total_q      <= '0;
        seen_mask_q  <= '0;
        newest_q     <= '0;
        best_found_q <= 1'b0;
        best_chars_q <= skcw_pkg::CHR_MAX;
        best_begin_q <= '0;
        best_end_q   <= '0;
      end else if (acc) begin
        word_cnt_q   <= pend;
        char_cnt_q   <= cend;
        total_q      <= total_d;
        seen_mask_q  <= seen_mask_d;
        newest_q     <= newest_d;
        best_found_q <= best_found_d;
        best_chars_q <= best_chars_d;
        best_begin_q <= best_begin_d;
        best_end_q   <= best_end_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      out_q <= out_d;
    end
  end

  assign result_o.valid            = out_valid_q;
  assign result_o.all_found        = out_q.all_found;
  assign result_o.window_begin     = out_q.window_begin;
  assign result_o.window_end       = out_q.window_end;
  assign result_o.window_chars     = out_q.window_chars;
  assign result_o.matched_keywords = out_q.matched_keywords;
  assign result_o.final_result     = out_q.final_result;

  `SKCW_ASSERT_IMP(a_total_matches_mask, 1'b1, 32'(total_q) == $countones(seen_mask_q))
  `SKCW_ASSERT_NEXT(a_text_end_clears, acc && last, total_q == '0 && !best_found_q)
  `SKCW_ASSERT_NEXT(a_best_narrows, best_found_q && !(acc && last),
                    best_found_q && (best_chars_q <= $past(best_chars_q)))
  `SKCW_ASSERT_NEXT(a_result_loaded, acc, out_valid_q)

endmodule
